>>> design/modbus_rtu_command_frame_builder_assert.svh
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define MODBUS_RTU_COMMAND_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define MRFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mrfb_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - package
// Frame constants, opcode codes, byte selection and CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package mrfb_pkg;

	// opcodes
	localparam logic OP_MODE = 1'b0;
	localparam logic OP_POS  = 1'b1;

	// address register reset value
	localparam logic [7:0] ADDR_RESET = 8'h01;

	// CRC-16/Modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// mode frame payload
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] MODE_REG_HI     = 8'h51;
	localparam logic [7:0] MODE_REG_LO     = 8'h00;
	localparam logic [7:0] MODE_VAL_HI     = 8'h01;
	localparam logic [7:0] MODE_VAL_LO     = 8'h52;

	// position frame payload
	localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
	localparam logic [7:0] POS_REG_HI      = 8'h00;
	localparam logic [7:0] POS_REG_LO      = 8'h50;
	localparam logic [7:0] POS_CNT_HI      = 8'h00;
	localparam logic [7:0] POS_CNT_LO      = 8'h02;
	localparam logic [7:0] POS_BYTE_CNT    = 8'h04;

	// byte index within a frame
	localparam int IDX_W = 4;
	typedef logic [IDX_W-1:0] idx_t;
	localparam idx_t LAST_MODE = idx_t'(7);
	localparam idx_t LAST_POS  = idx_t'(12);

	// one CRC-16/Modbus byte update, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// header and payload byte at a given index (CRC bytes handled elsewhere)
	function automatic logic [7:0] data_byte(input logic opc, input idx_t idx,
			input logic [7:0] addr, input logic [31:0] pos);
		logic [7:0] b;
		b = 8'h00;
		if (opc == OP_MODE) begin
			unique case (idx)
				idx_t'(0): b = addr;
				idx_t'(1): b = FC_WRITE_SINGLE;
				idx_t'(2): b = MODE_REG_HI;
				idx_t'(3): b = MODE_REG_LO;
				idx_t'(4): b = MODE_VAL_HI;
				idx_t'(5): b = MODE_VAL_LO;
				default:   b = 8'h00;
			endcase
		end else begin
			unique case (idx)
				idx_t'(0):  b = addr;
				idx_t'(1):  b = FC_WRITE_MULTI;
				idx_t'(2):  b = POS_REG_HI;
				idx_t'(3):  b = POS_REG_LO;
				idx_t'(4):  b = POS_CNT_HI;
				idx_t'(5):  b = POS_CNT_LO;
				idx_t'(6):  b = POS_BYTE_CNT;
				idx_t'(7):  b = pos[31:24];
				idx_t'(8):  b = pos[23:16];
				idx_t'(9):  b = pos[15:8];
				idx_t'(10): b = pos[7:0];
				default:    b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

>>> design/mrfb_if.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - channel interfaces
// Valid/ready channels for commands, frame bytes and the address register.
// ----------------------------------------------------------------------------

// command channel
interface mrfb_cmd_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] position;

	modport source (output valid, output opcode, output position, input ready);
	modport sink   (input valid, input opcode, input position, output ready);
endinterface

// frame byte channel
interface mrfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source (output valid, output frame_byte, output last, input ready);
	modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

// address register write channel
interface mrfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] slave_address;

	modport source (output valid, output slave_address, input ready);
	modport sink   (input valid, input slave_address, output ready);
endinterface

>>> design/modbus_rtu_command_frame_builder.sv
// The first frame byte is formed from the command register, then registered
// in the output stage. Mode frames are 8 bytes and position frames 13, one
// byte a cycle unless the output stalls; the next command is taken in the
// cycle the final CRC byte is loaded. CRC update: eight steps per data byte.
// Reset: asynchronous, clears the frame control and output valid; the device
// address returns to 1.
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - top level
// Turns mode and position commands into Modbus RTU frames with CRC-16.
// ----------------------------------------------------------------------------
module modbus_rtu_command_frame_builder
	import mrfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mrfb_cfg_if.sink    cfg,
	mrfb_cmd_if.sink    cmd,
	mrfb_byte_if.source frame
);

	logic [7:0] addr;

	// device address register
	mrfb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.addr   (addr)
	);

	// frame build and serialization
	mrfb_ser u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (addr),
		.cmd    (cmd),
		.frame  (frame)
	);

endmodule

>>> design/mrfb_cfg.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - address register
// Holds the device address placed in the first byte of every frame.
// ----------------------------------------------------------------------------
module mrfb_cfg
	import mrfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mrfb_cfg_if.sink    cfg,
	output logic [7:0]  addr
);

	logic [7:0] addr_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg.valid) begin
			addr_q <= cfg.slave_address;
		end
	end

	assign addr = addr_q;

endmodule

>>> design/mrfb_ser.sv
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - frame serializer
// Command register, byte index and running CRC; one frame byte per cycle
// into a registered output stage while the receiver does not stall it.
// ----------------------------------------------------------------------------
`include "modbus_rtu_command_frame_builder_assert.svh"

module mrfb_ser
	import mrfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  addr,
	mrfb_cmd_if.sink    cmd,
	mrfb_byte_if.source frame
);

	// command register and frame progress
	logic        busy_q;
	idx_t        idx_q;
	logic        opc_q;
	logic [31:0] pos_q;
	logic [15:0] crc_q;

	// output register
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q;

	logic        adv;
	logic        fin;
	logic        ld;
	idx_t        last_idx;
	logic        is_crc_lo;
	logic        is_crc_hi;
	logic [7:0]  cur_byte;

	// output stage can take a byte
	assign adv      = !ovalid_q || frame.ready;
	assign last_idx = (opc_q == OP_POS) ? LAST_POS : LAST_MODE;
	assign fin      = busy_q && adv && (idx_q == last_idx);

	// next item enters as the current frame hands over its final byte
	assign cmd.ready = !busy_q || fin;
	assign ld        = cmd.valid && cmd.ready;

	// byte select: header/payload, then CRC low, then CRC high
	assign is_crc_lo = (idx_q == idx_t'(last_idx - idx_t'(1)));
	assign is_crc_hi = (idx_q == last_idx);

	always_comb begin
		if (is_crc_hi) begin
			cur_byte = crc_q[15:8];
		end else if (is_crc_lo) begin
			cur_byte = crc_q[7:0];
		end else begin
			cur_byte = data_byte(opc_q, idx_q, addr, pos_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ld) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (busy_q && adv) begin
				idx_q <= idx_q + idx_t'(1);
			end
			if (adv) begin
				ovalid_q <= busy_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld) begin
			opc_q <= cmd.opcode;
			pos_q <= cmd.position;
			crc_q <= CRC_INIT;
		end else if (busy_q && adv && !is_crc_lo && !is_crc_hi) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
		if (busy_q && adv) begin
			obyte_q <= cur_byte;
			olast_q <= is_crc_hi;
		end
	end

	assign frame.valid      = ovalid_q;
	assign frame.frame_byte = obyte_q;
	assign frame.last       = olast_q;

	// checks
	`MRFB_ASSERT_NOW(a_ld_only_free, ld, !busy_q || fin, "item taken mid-frame")
	`MRFB_ASSERT_NEXT(a_fin_marks_last, fin, ovalid_q && olast_q, "final byte not marked last")
	`MRFB_ASSERT_NEXT(a_ld_starts, ld, busy_q && (idx_q == '0), "frame did not start at byte 0")
	`MRFB_ASSERT_NOW(a_idx_range, busy_q, idx_q <= last_idx, "byte index past frame end")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU frame builder - regression bench
// Sends mode and position commands through the command channel, rewrites the
// device address between phases and checks every frame byte and its last flag
// against frames rebuilt here, CRC-16/Modbus included.
// ----------------------------------------------------------------------------
module tb;
	import mrfb_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 180;
	localparam int RANDOM_ITEMS = 374;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] octet;
		logic       is_last;
	} frame_octet_t;

	logic clk;
	logic arst_n;

	mrfb_cmd_if  cmd_ch ();
	mrfb_byte_if frame_ch ();
	mrfb_cfg_if  cfg_ch ();

	modbus_rtu_command_frame_builder uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.cmd   (cmd_ch),
		.frame (frame_ch)
	);

	// expected frame bytes, oldest first
	frame_octet_t frame_q [$];
	logic [7:0]   dev_address;

	int mismatches;
	int octets_checked;
	int mode_frames;
	int pos_frames;
	int address_writes;
	int idle_cycles;

	// stall control, written by the test sequence only
	logic no_stall;
	int   hold_req;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// CRC-16/Modbus, one input bit at a time, LSB first
	function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
			input logic [7:0] octet);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ octet[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// rebuild the frame for one command and queue its bytes
	function automatic void predict_frame(input logic opc, input logic [31:0] pos);
		logic [7:0]  body [0:10];
		int          len;
		logic [15:0] crc;
		body[0] = dev_address;
		if (opc == OP_MODE) begin
			body[1] = FC_WRITE_SINGLE;
			body[2] = MODE_REG_HI;
			body[3] = MODE_REG_LO;
			body[4] = MODE_VAL_HI;
			body[5] = MODE_VAL_LO;
			len = 6;
		end else begin
			body[1] = FC_WRITE_MULTI;
			body[2] = POS_REG_HI;
			body[3] = POS_REG_LO;
			body[4] = POS_CNT_HI;
			body[5] = POS_CNT_LO;
			body[6] = POS_BYTE_CNT;
			{body[7], body[8], body[9], body[10]} = pos;
			len = 11;
		end
		crc = CRC_INIT;
		for (int k = 0; k < len; k++) begin
			crc = crc16_modbus_next(crc, body[k]);
			frame_q.push_back('{octet: body[k], is_last: 1'b0});
		end
		// CRC goes out low byte first
		frame_q.push_back('{octet: crc[7:0], is_last: 1'b0});
		frame_q.push_back('{octet: crc[15:8], is_last: 1'b1});
	endfunction

	// frame byte check, address tracking and command prediction
	always @(posedge clk) begin
		frame_octet_t exp_oct;
		if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready) begin
				octets_checked++;
				if (frame_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected frame byte %h last %b", $time,
							frame_ch.frame_byte, frame_ch.last);
				end else begin
					exp_oct = frame_q.pop_front();
					if (exp_oct.octet !== frame_ch.frame_byte ||
							exp_oct.is_last !== frame_ch.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: frame byte exp %h last %b, got %h last %b",
								$time, exp_oct.octet, exp_oct.is_last,
								frame_ch.frame_byte, frame_ch.last);
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				dev_address = cfg_ch.slave_address;
				address_writes++;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_frame(cmd_ch.opcode, cmd_ch.position);
				if (cmd_ch.opcode == OP_MODE)
					mode_frames++;
				else
					pos_frames++;
			end
		end
	end

	// watchdog: cycles without any item moved
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d bytes pending", $time,
				idle_cycles, frame_q.size());
			$display("modbus_rtu_command_frame_builder regression: fail");
			$finish;
		end
	end

	// frame receiver: random stalls, long hold-off on request
	initial begin
		int hold_ack;
		int hold_left;
		hold_ack = 0;
		hold_left = 0;
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= no_stall || ($urandom_range(99) >= 9);
			end
		end
	end

	// offer one command; valid stays high after acceptance
	task automatic send_cmd(input logic opc, input logic [31:0] pos);
		if (!no_stall && $urandom_range(99) < 9) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= opc;
		cmd_ch.position <= pos;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// stop sending and wait until every expected byte is out
	task automatic drain;
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_address(input logic [7:0] addr);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.slave_address <= addr;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_position();
		logic [31:0] p;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: p = 32'h0000_0000;
					1: p = 32'hFFFF_FFFF;
					2: p = 32'h7FFF_FFFF;
					default: p = 32'h8000_0000;
				endcase
			end
			// small magnitude, either sign
			1: p = $urandom_range(0, 1) ? 32'($urandom_range(0, 511)) :
				-32'($urandom_range(1, 511));
			default: p = $urandom;
		endcase
		return p;
	endfunction

	// frames right after reset use the default address
	task automatic test_default_address;
		send_cmd(OP_MODE, 32'h0000_0000);
		send_cmd(OP_POS, 32'h0000_0000);
		drain();
	endtask

	// position extremes and bit patterns; mode ignores the position
	task automatic test_position_extremes;
		send_cmd(OP_POS, 32'h0000_0001);
		send_cmd(OP_POS, 32'hFFFF_FFFF);
		send_cmd(OP_POS, 32'h7FFF_FFFF);
		send_cmd(OP_POS, 32'h8000_0000);
		send_cmd(OP_POS, 32'hAAAA_AAAA);
		send_cmd(OP_POS, 32'h5555_5555);
		send_cmd(OP_POS, 32'h1234_5678);
		send_cmd(OP_POS, -32'sd100000);
		send_cmd(OP_MODE, 32'hFFFF_FFFF);
		drain();
	endtask

	// address extremes in the first byte and in the CRC
	task automatic test_address_extremes;
		write_address(8'h00);
		send_cmd(OP_MODE, 32'h0);
		send_cmd(OP_POS, 32'hDEAD_BEEF);
		write_address(8'hFF);
		send_cmd(OP_MODE, 32'h0);
		send_cmd(OP_POS, 32'h0102_0304);
		write_address(8'hA5);
		send_cmd(OP_MODE, 32'h5A5A_5A5A);
		drain();
	endtask

	// receiver holds off while commands keep coming, so the input stalls
	task automatic test_output_hold_off;
		no_stall <= 1'b1;
		hold_req <= hold_req + 1;
		for (int i = 0; i < 12; i++)
			send_cmd(i[0] ? OP_POS : OP_MODE, $urandom);
		drain();
		no_stall <= 1'b0;
	endtask

	// sender pauses until the pipeline is empty, then resumes
	task automatic test_sender_pause;
		for (int i = 0; i < 6; i++)
			send_cmd(OP_POS, $urandom);
		drain();
		for (int i = 0; i < 6; i++)
			send_cmd(1'($urandom_range(0, 1)), $urandom);
		drain();
	endtask

	// random commands, address changes between phases, one stall-free stretch
	task automatic test_random_commands;
		logic [7:0] addr;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 60 == 59) begin
				case ($urandom_range(0, 3))
					0: addr = 8'h00;
					1: addr = 8'hFF;
					default: addr = 8'($urandom);
				endcase
				write_address(addr);
			end
			if (i == 150)
				no_stall <= 1'b1;
			if (i == 250)
				no_stall <= 1'b0;
			send_cmd(1'($urandom_range(0, 1)), pick_position());
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		dev_address = ADDR_RESET;
		mismatches = 0;
		octets_checked = 0;
		mode_frames = 0;
		pos_frames = 0;
		address_writes = 0;
		idle_cycles = 0;
		no_stall <= 1'b0;
		hold_req <= 0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.opcode <= OP_MODE;
		cmd_ch.position <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.slave_address <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_address();
		test_position_extremes();
		test_address_extremes();
		test_output_hold_off();
		test_sender_pause();
		test_random_commands();

		$display("covered %0d mode and %0d position frames, %0d bytes checked",
			mode_frames, pos_frames, octets_checked);
		$display("%0d address writes, %0d mismatches", address_writes, mismatches);
		if (mismatches == 0)
			$display("modbus_rtu_command_frame_builder regression: pass");
		else
			$display("modbus_rtu_command_frame_builder regression: fail");
		$finish;
	end

endmodule
